// ===== hw/rtl/rtpj_pkg.sv =====
// shared types and constants for the rtp interarrival jitter estimator
// no dependencies; used by the front, queue, back and top modules by scoped names
package rtpj_pkg;

    localparam int RTP_W    = 32;
    localparam int TICK_W   = 40;
    localparam int RATE_W   = 24;
    localparam int COUNT_W  = 32;
    localparam int GSUM_W   = 64;

    localparam logic [RATE_W-1:0] DEFAULT_RATE = 24'd90000;

    // one classified packet passed from the front to the back
    typedef struct packed {
        logic              is_first;
        logic [RTP_W-1:0]  rtp_time;
        logic [TICK_W-1:0] elapsed;
        logic [TICK_W-1:0] gap;
    } t_item;

endpackage

// ===== hw/rtl/rtpj_fifo.sv =====
// two-entry queue of classified packets between front and back
// depends on rtpj_pkg for the item type
module rtpj_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rtpj_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_avail,
    output rtpj_pkg::t_item o_item
);

    rtpj_pkg::t_item r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 2'd1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

// ===== hw/rtl/rtpj_muldiv.sv =====
// iterative unit: floor(a * b / d), shift-add multiply then restoring divide
// one bit per cycle in each phase; no package dependencies
module rtpj_muldiv #(
    parameter int PW = 80,
    parameter int DW = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PW-1:0] i_a,
    input  logic [DW-1:0] i_b,
    input  logic [DW-1:0] i_d,
    output logic          o_done,
    output logic [PW-1:0] o_q
);

    localparam int CW = $clog2(PW + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} t_state;

    t_state        r_state;
    logic [PW-1:0] r_a;
    logic [DW-1:0] r_b;
    logic [DW-1:0] r_d;
    logic [PW-1:0] r_acc;
    logic [DW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_done;

    logic [DW:0]   rem_sh;
    logic          fits;

    // one restoring step
    always_comb begin
        rem_sh = {r_rem, r_acc[PW-1]};
        fits   = (rem_sh >= {1'b0, r_d});
    end

    assign o_done = r_done;
    assign o_q    = r_acc;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            // done pulse after the last divide step
            r_done <= (r_state == ST_DIV) && (r_cnt == CW'(1));
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_d     <= i_d;
                        r_acc   <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_b == '0) begin
                        r_rem   <= '0;
                        r_cnt   <= CW'(PW);
                        r_state <= ST_DIV;
                    end else begin
                        if (r_b[0]) r_acc <= r_acc + r_a;
                        r_a <= {r_a[PW-2:0], 1'b0};
                        r_b <= {1'b0, r_b[DW-1:1]};
                    end
                end
                ST_DIV: begin
                    r_rem <= fits ? DW'(rem_sh - {1'b0, r_d}) : rem_sh[DW-1:0];
                    r_acc <= {r_acc[PW-2:0], fits};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/rtpj_front.sv =====
// front end: accepts packets, fixes the time origin, computes elapsed and gap
// depends on rtpj_pkg for widths and the item type
module rtpj_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rtpj_pkg::RTP_W-1:0]  i_rtp_time,
    input  logic [rtpj_pkg::TICK_W-1:0] i_arrival_ticks,
    input  logic                        i_full,
    output logic                        o_push,
    output rtpj_pkg::t_item             o_item
);

    logic                        r_seen;
    logic [rtpj_pkg::TICK_W-1:0] r_origin;
    logic [rtpj_pkg::TICK_W-1:0] r_last;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // classify the packet
    always_comb begin
        o_item.is_first = !r_seen;
        o_item.rtp_time = i_rtp_time;
        o_item.elapsed  = r_seen ? (i_arrival_ticks - r_origin) : '0;
        o_item.gap      = i_arrival_ticks - r_last;
    end

    // origin and last arrival
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= 1'b0;
            r_origin <= '0;
            r_last   <= '0;
        end else if (o_push) begin
            r_seen <= 1'b1;
            r_last <= i_arrival_ticks;
            if (!r_seen) r_origin <= i_arrival_ticks;
        end
    end

endmodule

// ===== hw/rtl/rtpj_back.sv =====
// back end: media-unit conversion, jitter filter, gap statistics, snapshot
// depends on rtpj_pkg and rtpj_muldiv
module rtpj_back #(
    parameter int TICKS_PER_SECOND = 1000000,
    parameter int JITTER_FRAC_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rtpj_pkg::RATE_W-1:0]  i_cfg_wdata,
    input  logic                         i_avail,
    input  rtpj_pkg::t_item              i_item,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rtpj_pkg::COUNT_W-1:0] o_packet_count,
    output logic [rtpj_pkg::TICK_W-1:0]  o_jitter_units_q8,
    output logic [rtpj_pkg::TICK_W-1:0]  o_jitter_in_ticks,
    output logic [rtpj_pkg::TICK_W-1:0]  o_mean_gap_ticks,
    output logic [rtpj_pkg::TICK_W-1:0]  o_largest_gap_ticks
);

    localparam int TW  = 32 + JITTER_FRAC_BITS;
    localparam int PW  = (64 + JITTER_FRAC_BITS > 70) ? 64 + JITTER_FRAC_BITS : 70;
    localparam int DW  = (24 + JITTER_FRAC_BITS > 32) ? 24 + JITTER_FRAC_BITS : 32;
    localparam int SW  = ((TW > 44) ? TW : 44) + 1;
    localparam int TKW = rtpj_pkg::TICK_W;
    localparam int CNW = rtpj_pkg::COUNT_W;
    localparam int GSW = rtpj_pkg::GSUM_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_UNITS, ST_UPDATE, ST_JIT, ST_TICKS, ST_MEAN, ST_DONE
    } t_state;

    t_state             r_state;
    rtpj_pkg::t_item    r_item;
    logic [rtpj_pkg::RATE_W-1:0] r_rate;
    logic [TW-1:0]      r_units;
    logic [TW-1:0]      r_transit;
    logic [TW-1:0]      r_mag;
    logic [TKW-1:0]     r_jitter;
    logic [GSW-1:0]     r_gap_total;
    logic [TKW-1:0]     r_gap_max;
    logic [CNW-1:0]     r_count;
    logic [TKW-1:0]     r_ticks;
    logic [TKW-1:0]     r_mean;
    logic               r_start;
    logic               r_valid;
    logic [CNW-1:0]     r_o_count;
    logic [TKW-1:0]     r_o_jit;
    logic [TKW-1:0]     r_o_ticks;
    logic [TKW-1:0]     r_o_mean;
    logic [TKW-1:0]     r_o_max;

    logic [rtpj_pkg::RATE_W-1:0] eff_rate;
    logic [DW-1:0]      rate_sh;
    logic [PW-1:0]      md_a;
    logic [DW-1:0]      md_b;
    logic [DW-1:0]      md_d;
    logic               md_done;
    logic [PW-1:0]      md_q;
    logic [TKW-1:0]     q_sat;
    logic [TW-1:0]      transit;
    logic [TW-1:0]      diff;
    logic [GSW:0]       gsum;
    logic [SW-1:0]      jsum;
    logic               out_free;

    // effective rate and its fixed-point scaling
    assign eff_rate = (r_rate == '0) ? rtpj_pkg::DEFAULT_RATE : r_rate;
    assign rate_sh  = DW'(eff_rate) << JITTER_FRAC_BITS;

    // operand select for the shared multiply-divide unit
    always_comb begin
        case (r_state)
            ST_UNITS: begin
                md_a = PW'(r_item.elapsed);
                md_b = rate_sh;
                md_d = DW'(TICKS_PER_SECOND);
            end
            ST_TICKS: begin
                md_a = PW'(r_jitter);
                md_b = DW'(TICKS_PER_SECOND);
                md_d = rate_sh;
            end
            default: begin
                md_a = PW'(r_gap_total);
                md_b = DW'(1);
                md_d = DW'(r_count - CNW'(1));
            end
        endcase
    end

    rtpj_muldiv #(.PW(PW), .DW(DW)) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_a     (md_a),
        .i_b     (md_b),
        .i_d     (md_d),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    // quotient saturated to the tick width
    assign q_sat = (|md_q[PW-1:TKW]) ? '1 : md_q[TKW-1:0];

    // transit, transit difference, gap sum, filter step
    always_comb begin
        transit = r_units - (TW'(r_item.rtp_time) << JITTER_FRAC_BITS);
        diff    = transit - r_transit;
        gsum    = {1'b0, r_gap_total} + (GSW+1)'(r_item.gap);
        jsum    = (SW'(r_jitter) << 4) - SW'(r_jitter) + SW'(r_mag);
    end

    assign out_free = !r_valid || i_ready;
    assign o_pop    = (r_state == ST_IDLE) && i_avail;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rate <= rtpj_pkg::DEFAULT_RATE;
        else if (i_cfg_we) r_rate <= i_cfg_wdata;
    end

    // sequencer, statistics state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_valid     <= 1'b0;
            r_transit   <= '0;
            r_jitter    <= '0;
            r_gap_total <= '0;
            r_gap_max   <= '0;
            r_count     <= '0;
        end else begin
            // start pulses for the multiply-divide passes
            r_start <= ((r_state == ST_IDLE) && i_avail) || (r_state == ST_JIT) ||
                       ((r_state == ST_TICKS) && md_done && (r_count > CNW'(1)));
            // output valid: set on a new snapshot, cleared on transfer
            if ((r_state == ST_DONE) && out_free) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_avail) begin
                        r_item  <= i_item;
                        r_state <= ST_UNITS;
                    end
                end
                ST_UNITS: begin
                    if (md_done) begin
                        r_units <= md_q[TW-1:0];
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    r_transit <= transit;
                    r_mag     <= diff[TW-1] ? (TW'(0) - diff) : diff;
                    if (!r_item.is_first) begin
                        r_gap_total <= gsum[GSW] ? '1 : gsum[GSW-1:0];
                        if (r_item.gap > r_gap_max) r_gap_max <= r_item.gap;
                    end
                    if (r_count != '1) r_count <= r_count + CNW'(1);
                    r_state <= ST_JIT;
                end
                ST_JIT: begin
                    if (!r_item.is_first) begin
                        r_jitter <= (|jsum[SW-1:TKW+4]) ? '1 : jsum[TKW+3:4];
                    end
                    r_state <= ST_TICKS;
                end
                ST_TICKS: begin
                    if (md_done) begin
                        r_ticks <= q_sat;
                        if (r_count > CNW'(1)) begin
                            r_state <= ST_MEAN;
                        end else begin
                            r_mean  <= '0;
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_MEAN: begin
                    if (md_done) begin
                        r_mean  <= q_sat;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_o_count <= r_count;
                        r_o_jit   <= r_jitter;
                        r_o_ticks <= r_ticks;
                        r_o_mean  <= r_mean;
                        r_o_max   <= r_gap_max;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid             = r_valid;
    assign o_packet_count      = r_o_count;
    assign o_jitter_units_q8   = r_o_jit;
    assign o_jitter_in_ticks   = r_o_ticks;
    assign o_mean_gap_ticks    = r_o_mean;
    assign o_largest_gap_ticks = r_o_max;

endmodule

// ===== hw/rtl/rtp_interarrival_jitter_estimator.sv =====
// RTP interarrival jitter estimator (RFC 3550 filter) with gap statistics.
// Input channel (i_in_valid / o_in_ready) takes one packet per transfer:
// its RTP timestamp and its 40-bit local arrival tick count. Output channel
// (o_out_valid / i_out_ready) gives one snapshot per packet: packet count,
// jitter in media units (JITTER_FRAC_BITS fraction bits), jitter in ticks,
// mean gap and largest gap. i_cfg_we / i_cfg_wdata write the media clock
// rate (0 selects 90000); write it only while no packet is in flight.
// The front stage writes each accepted packet straight into a two-entry queue,
// so o_in_ready stays high until the queue fills. The back stage handles one
// packet at a time on a shared bit-serial multiply-divide unit: three passes,
// each a start, a shift-add multiply over the multiplier bits, a restoring
// divide over PW quotient bits and a hand-back (PW = max(64+F,70),
// DW = max(24+F,32)). The first packet skips the mean pass.
// A stalled receiver holds the snapshot in the output register; the back
// stage waits with the next one finished and the queue then fills.
// Synchronous active-low reset clears all statistics and sets the rate to
// 90000; the next packet after reset sets the time origin.
module rtp_interarrival_jitter_estimator #(
    parameter int TICKS_PER_SECOND = 1000000,
    parameter int JITTER_FRAC_BITS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [31:0]  i_rtp_time,
    input  logic [39:0]  i_arrival_ticks,
    input  logic         i_cfg_we,
    input  logic [23:0]  i_cfg_wdata,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [31:0]  o_packet_count,
    output logic [39:0]  o_jitter_units_q8,
    output logic [39:0]  o_jitter_in_ticks,
    output logic [39:0]  o_mean_gap_ticks,
    output logic [39:0]  o_largest_gap_ticks
);

    logic            push;
    logic            full;
    logic            pop;
    logic            avail;
    rtpj_pkg::t_item f_item;
    rtpj_pkg::t_item q_item;

    // packet classification
    rtpj_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_rtp_time      (i_rtp_time),
        .i_arrival_ticks (i_arrival_ticks),
        .i_full          (full),
        .o_push          (push),
        .o_item          (f_item)
    );

    // decoupling queue
    rtpj_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_item  (q_item)
    );

    // arithmetic and snapshot
    rtpj_back #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .JITTER_FRAC_BITS (JITTER_FRAC_BITS)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_avail             (avail),
        .i_item              (q_item),
        .o_pop               (pop),
        .o_valid             (o_out_valid),
        .i_ready             (i_out_ready),
        .o_packet_count      (o_packet_count),
        .o_jitter_units_q8   (o_jitter_units_q8),
        .o_jitter_in_ticks   (o_jitter_in_ticks),
        .o_mean_gap_ticks    (o_mean_gap_ticks),
        .o_largest_gap_ticks (o_largest_gap_ticks)
    );

endmodule

// ===== test/tb_rtp_interarrival_jitter_estimator.sv =====
// self-checking bench for rtp_interarrival_jitter_estimator: directed packets,
// then random packet streams at several media clock rates
// depends on rtpj_pkg and the estimator rtl only
module tb_rtp_interarrival_jitter_estimator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RTP_W   = rtpj_pkg::RTP_W;
    localparam int TICK_W  = rtpj_pkg::TICK_W;
    localparam int RATE_W  = rtpj_pkg::RATE_W;
    localparam int COUNT_W = rtpj_pkg::COUNT_W;
    localparam int GSUM_W  = rtpj_pkg::GSUM_W;
    localparam longint unsigned TPS = 1000000;
    localparam int FRAC = 8;
    localparam int TRANSIT_W = RTP_W + FRAC;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [TICK_W-1:0]  jitter_q8;
        logic [TICK_W-1:0]  jitter_ticks;
        logic [TICK_W-1:0]  mean_gap;
        logic [TICK_W-1:0]  largest_gap;
    } t_snapshot;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [RTP_W-1:0]   i_rtp_time;
    logic [TICK_W-1:0]  i_arrival_ticks;
    logic               i_cfg_we;
    logic [RATE_W-1:0]  i_cfg_wdata;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [COUNT_W-1:0] o_packet_count;
    logic [TICK_W-1:0]  o_jitter_units_q8;
    logic [TICK_W-1:0]  o_jitter_in_ticks;
    logic [TICK_W-1:0]  o_mean_gap_ticks;
    logic [TICK_W-1:0]  o_largest_gap_ticks;

    // jitter estimate state mirrored by the bench
    logic [RATE_W-1:0]    rate_reg;
    logic                 est_seen_first;
    logic [TICK_W-1:0]    est_origin;
    logic [TICK_W-1:0]    est_last_arrival;
    logic [TRANSIT_W-1:0] est_last_transit;
    logic [TICK_W-1:0]    est_jitter;
    logic [GSUM_W-1:0]    est_gap_total;
    logic [TICK_W-1:0]    est_gap_max;
    logic [COUNT_W-1:0]   est_packets;

    t_snapshot expected_snapshots[$];
    int error_count;
    int idle_cycles;
    int burst_left;
    int stall_mode;
    int stall_left;

    rtp_interarrival_jitter_estimator uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_rtp_time          (i_rtp_time),
        .i_arrival_ticks     (i_arrival_ticks),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_packet_count      (o_packet_count),
        .o_jitter_units_q8   (o_jitter_units_q8),
        .o_jitter_in_ticks   (o_jitter_in_ticks),
        .o_mean_gap_ticks    (o_mean_gap_ticks),
        .o_largest_gap_ticks (o_largest_gap_ticks)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [47:0] scaled_rate();
        logic [RATE_W-1:0] r;
        r = (rate_reg == '0) ? rtpj_pkg::DEFAULT_RATE : rate_reg;
        return {24'd0, r} << FRAC;
    endfunction

    // advance the mirrored estimator by one packet and return its snapshot
    function automatic t_snapshot update_jitter(logic [RTP_W-1:0] rtp,
                                                logic [TICK_W-1:0] now);
        t_snapshot s;
        logic [127:0] wide;
        logic [TICK_W-1:0] elapsed, gap;
        logic [TRANSIT_W-1:0] units, transit, diff, mag;
        logic [47:0] filt;
        logic [64:0] sum;
        if (!est_seen_first) begin
            est_origin = now;
            est_seen_first = 1'b1;
        end
        elapsed = now - est_origin;
        wide = ({88'd0, elapsed} * {80'd0, scaled_rate()}) / {64'd0, TPS};
        units = wide[TRANSIT_W-1:0];
        transit = units - ({8'd0, rtp} << FRAC);
        if (est_packets != '0) begin
            gap = now - est_last_arrival;
            diff = transit - est_last_transit;
            mag = diff[TRANSIT_W-1] ? -diff : diff;
            sum = {1'b0, est_gap_total} + {25'd0, gap};
            est_gap_total = sum[64] ? '1 : sum[63:0];
            if (gap > est_gap_max) est_gap_max = gap;
            filt = (48'd15 * {8'd0, est_jitter} + {8'd0, mag}) >> 4;
            est_jitter = (filt > {8'd0, TICK_MAX}) ? TICK_MAX : filt[TICK_W-1:0];
        end
        est_last_arrival = now;
        est_last_transit = transit;
        if (est_packets != '1) est_packets = est_packets + 32'd1;
        wide = ({88'd0, est_jitter} * {64'd0, TPS}) / {80'd0, scaled_rate()};
        s.count = est_packets;
        s.jitter_q8 = est_jitter;
        s.jitter_ticks = (wide > {88'd0, TICK_MAX}) ? TICK_MAX : wide[TICK_W-1:0];
        s.mean_gap = '0;
        if (est_packets > 32'd1) begin
            wide = {64'd0, est_gap_total} / {96'd0, est_packets - 32'd1};
            s.mean_gap = (wide > {88'd0, TICK_MAX}) ? TICK_MAX : wide[TICK_W-1:0];
        end
        s.largest_gap = est_gap_max;
        return s;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        error_count++;
    endtask

    // send one packet; the sender runs in bursts with random gaps between them
    task automatic send_packet(logic [RTP_W-1:0] rtp, logic [TICK_W-1:0] now);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_rtp_time <= rtp;
        i_arrival_ticks <= now;
        do @(posedge i_clk); while (!o_in_ready);
        expected_snapshots.push_back(update_jitter(rtp, now));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_snapshots.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // rate register write, only with nothing in flight
    task automatic write_clock_rate(logic [RATE_W-1:0] rate);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= rate;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rate_reg = rate;
    endtask

    // extremes, timestamp and tick wrap, most negative transit step
    task automatic test_directed_extremes();
        send_packet(32'hFFFF_FFFF, TICK_MAX);
        send_packet(32'h0000_0000, 40'd0);
        send_packet(32'h0000_0000, 40'd0);
        send_packet(32'h8000_0000, 40'd0);
        send_packet(32'h0000_0000, 40'd0);
        send_packet(32'hFFFF_FFF0, 40'd1000);
        send_packet(32'h0000_0010, 40'd1100);
        send_packet(32'h5555_5555, 40'h55_5555_5555);
        send_packet(32'hAAAA_AAAA, 40'hAA_AAAA_AAAA);
        send_packet(32'h0000_0001, 40'h00_0000_0001);
        send_packet(32'hFFFF_FFFF, TICK_MAX);
        send_packet(32'd12345, 40'h80_0000_0000);
        send_packet(32'd12345, 40'h7F_FFFF_FFFF);
        write_clock_rate('0);
        send_packet(32'd90, 40'h80_0000_1000);
        send_packet(32'd180, 40'h80_0000_2000);
        write_clock_rate(24'hFF_FFFF);
        send_packet(32'd0, TICK_MAX);
        send_packet(32'hFFFF_FFFF, 40'd5);
        write_clock_rate(24'd1);
        send_packet(32'd0, 40'd1_000_000);
        send_packet(32'd3, 40'd2_000_000);
    endtask

    // paced stream with random content, plus noise and out-of-order arrivals
    task automatic test_random_stream(logic [RATE_W-1:0] rate, int count);
        logic [RTP_W-1:0] rtp;
        logic [TICK_W-1:0] now;
        longint unsigned step, eff;
        write_clock_rate(rate);
        eff = (rate == '0) ? {40'd0, rtpj_pkg::DEFAULT_RATE} : {40'd0, rate};
        rtp = $urandom();
        now = {8'($urandom_range(0, 255)), $urandom()};
        for (int n = 0; n < count; n++) begin
            step = {32'd0, $urandom_range(1, 40000)};
            now = TICK_W'({24'd0, now} + step);
            rtp = RTP_W'({32'd0, rtp} + (step * eff) / TPS
                         + {32'd0, $urandom_range(0, 20)} - 64'd10);
            case ($urandom_range(0, 19))
                0: send_packet($urandom(), {8'($urandom_range(0, 255)), $urandom()});
                1: send_packet(rtp, now - {8'd0, $urandom_range(1, 5000)});
                2: send_packet(rtp ^ (32'h1 << $urandom_range(0, 31)), now);
                default: send_packet(rtp, now);
            endcase
        end
    endtask

    // receiver stalls: always ready, random stalls, or long stalls, mode picked at random
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(100, 2000);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= ($urandom_range(0, 15) == 0) ? ~i_out_ready : i_out_ready;
        endcase
    end

    // compare each result transfer with the oldest expected snapshot
    always @(posedge i_clk) begin
        t_snapshot want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_snapshots.size() == 0) begin
                report_mismatch("unexpected result", 64'd1, 64'd0);
            end else begin
                want = expected_snapshots.pop_front();
                if (o_packet_count !== want.count)
                    report_mismatch("packet_count", 64'(o_packet_count), 64'(want.count));
                if (o_jitter_units_q8 !== want.jitter_q8)
                    report_mismatch("jitter_units_q8", 64'(o_jitter_units_q8),
                                    64'(want.jitter_q8));
                if (o_jitter_in_ticks !== want.jitter_ticks)
                    report_mismatch("jitter_in_ticks", 64'(o_jitter_in_ticks),
                                    64'(want.jitter_ticks));
                if (o_mean_gap_ticks !== want.mean_gap)
                    report_mismatch("mean_gap_ticks", 64'(o_mean_gap_ticks),
                                    64'(want.mean_gap));
                if (o_largest_gap_ticks !== want.largest_gap)
                    report_mismatch("largest_gap_ticks", 64'(o_largest_gap_ticks),
                                    64'(want.largest_gap));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("rtp_interarrival_jitter_estimator regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_rtp_time = '0;
        i_arrival_ticks = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_out_ready = 1'b1;
        error_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        rate_reg = rtpj_pkg::DEFAULT_RATE;
        est_seen_first = 1'b0;
        est_origin = '0;
        est_last_arrival = '0;
        est_last_transit = '0;
        est_jitter = '0;
        est_gap_total = '0;
        est_gap_max = '0;
        est_packets = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_random_stream(24'd90000, 270);
        test_random_stream(24'd8000, 270);
        test_random_stream(24'd48000, 270);
        test_random_stream('0, 270);
        test_random_stream(24'hFF_FFFF, 270);
        test_random_stream(24'd1, 270);

        wait_idle();
        if (error_count == 0)
            $display("rtp_interarrival_jitter_estimator regression: pass");
        else
            $display("rtp_interarrival_jitter_estimator regression: fail");
        $finish;
    end

endmodule
